@@ rtl/mstw_pkg.sv @@
// Package for the minimum spanning tree weight block.
// Fixed field widths, result limits and the pass unit control/status types.
// No dependencies.
`default_nettype none

package mstw_pkg;

    localparam int NODE_BITS      = 5;
    localparam int CFG_BITS       = 6;
    localparam int WEIGHT_IN_BITS = 16;
    localparam int TOTAL_BITS     = 21;

    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
    localparam logic [CFG_BITS-1:0]   CFG_RESET = 6'd32;

    typedef struct packed {
        logic init;    // clear tree and link valid bits, put node 0 in tree
        logic start;   // begin one scan over the active nodes
        logic commit;  // add the last pick to the tree
    } t_pass_ctl;

    typedef struct packed {
        logic done;    // last node of the scan is processed this cycle
        logic found;   // a reachable node outside the tree was seen
    } t_pass_sts;

endpackage

`default_nettype wire

@@ rtl/mstw_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// Used for the adjacency store and the best link store. No dependencies.
`default_nettype none

module mstw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/mstw_relax.sv @@
// Shared relax-and-select unit: one scan over the active nodes per tree step,
// updating best links and tracking the cheapest candidate. Uses mstw_pkg, mstw_ram.
`default_nettype none

module mstw_relax
    import mstw_pkg::*;
#(
    parameter int MAX_NODES = 32,
    parameter int WEIGHT_W  = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire t_pass_ctl                      i_ctl,
    input  wire logic [$clog2(MAX_NODES):0]     i_n,
    input  wire logic [WEIGHT_W:0]              i_adj_rdata,
    output logic      [$clog2(MAX_NODES)-1:0]   o_rd_node,
    output t_pass_sts                           o_sts,
    output logic      [$clog2(MAX_NODES)-1:0]   o_pick,
    output logic      [WEIGHT_W-1:0]            o_pw
);

    localparam int NB = $clog2(MAX_NODES);

    logic                 r_run, n_run;
    logic [NB:0]          r_cnt, n_cnt;
    logic [MAX_NODES-1:0] r_in_tree, n_in_tree;
    logic [MAX_NODES-1:0] r_bvalid, n_bvalid;
    logic                 r_found, n_found;
    logic [NB-1:0]        r_pick, n_pick;
    logic [WEIGHT_W-1:0]  r_pw, n_pw;

    logic [NB:0]          cnt_m1;
    logic [NB-1:0]        v;
    logic                 proc_vld;
    logic                 present;
    logic [WEIGHT_W-1:0]  w;
    logic [WEIGHT_W-1:0]  best_rdata;
    logic                 upd;
    logic                 cand_vld;
    logic [WEIGHT_W-1:0]  cand_w;
    logic                 take;
    logic                 done;

    mstw_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (MAX_NODES)
    ) u_best_ram (
        .i_clk   (i_clk),
        .i_we    (upd),
        .i_waddr (v),
        .i_wdata (w),
        .i_raddr (r_cnt[NB-1:0]),
        .o_rdata (best_rdata)
    );

    assign o_rd_node = r_cnt[NB-1:0];
    assign cnt_m1    = r_cnt - 1'b1;
    assign v         = cnt_m1[NB-1:0];
    assign proc_vld  = r_run && (r_cnt != '0);
    assign present   = i_adj_rdata[WEIGHT_W];
    assign w         = i_adj_rdata[WEIGHT_W-1:0];
    assign upd       = proc_vld && !r_in_tree[v] && present && (!r_bvalid[v] || w < best_rdata);
    assign cand_vld  = proc_vld && !r_in_tree[v] && (upd || r_bvalid[v]);
    assign cand_w    = upd ? w : best_rdata;
    assign take      = cand_vld && (!r_found || cand_w < r_pw);
    assign done      = r_run && (r_cnt == i_n);

    assign o_sts.done  = done;
    assign o_sts.found = r_found;
    assign o_pick      = r_pick;
    assign o_pw        = r_pw;

    always_comb begin
        n_run     = r_run;
        n_cnt     = r_cnt;
        n_in_tree = r_in_tree;
        n_bvalid  = r_bvalid;
        n_found   = r_found;
        n_pick    = r_pick;
        n_pw      = r_pw;

        if (upd) begin
            n_bvalid[v] = 1'b1;
        end
        if (take) begin
            n_found = 1'b1;
            n_pick  = v;
            n_pw    = cand_w;
        end
        if (r_run) begin
            if (done) begin
                n_run = 1'b0;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
        if (i_ctl.commit) begin
            n_in_tree[r_pick] = 1'b1;
        end
        if (i_ctl.init) begin
            n_in_tree    = '0;
            n_in_tree[0] = 1'b1;
            n_bvalid     = '0;
        end
        if (i_ctl.start) begin
            n_run   = 1'b1;
            n_cnt   = '0;
            n_found = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b0;
            r_cnt     <= '0;
            r_in_tree <= '0;
            r_bvalid  <= '0;
            r_found   <= 1'b0;
        end else begin
            r_run     <= n_run;
            r_cnt     <= n_cnt;
            r_in_tree <= n_in_tree;
            r_bvalid  <= n_bvalid;
            r_found   <= n_found;
        end
        r_pick <= n_pick;
        r_pw   <= n_pw;
    end

endmodule

`default_nettype wire

@@ rtl/min_spanning_tree_weight_top.sv @@
// Minimum spanning tree weight (Prim) top level: edge loading, sequencer,
// adjacency store clearing and result register. Uses mstw_pkg, mstw_ram, mstw_relax.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready) takes one edge per beat: node pair,
//   weight and a last flag. Edges load one per cycle while o_in_ready is high;
//   a later edge on the same pair replaces the earlier one. The beat with
//   last set starts the tree. Output channel (o_out_valid/i_out_ready)
//   carries one beat per graph with the tree weight (saturating) and a flag
//   telling whether every node in use was reached from node 0.
//   i_cfg_we/i_cfg_wdata write the node count; write only while idle.
//   Each tree step is one scan of the relax unit over the n active nodes,
//   one node per cycle, set by the single adjacency read port.
//   After each result, and after reset, the adjacency store is cleared one
//   entry per cycle, all MAX_NODES*MAX_NODES entries; o_in_ready stays low.
//   The result sits in an output register; if the receiver stalls, the clear
//   pass still runs and the block blocks only when a second result is ready.
//   Reset is synchronous, active low; node count returns to 32.
`default_nettype none

module min_spanning_tree_weight_top
    import mstw_pkg::*;
#(
    parameter int MAX_NODES   = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_BITS-1:0]       i_cfg_wdata,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [NODE_BITS-1:0]      i_node_a,
    input  wire logic [NODE_BITS-1:0]      i_node_b,
    input  wire logic [WEIGHT_IN_BITS-1:0] i_edge_weight,
    input  wire logic                      i_last_edge,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic      [TOTAL_BITS-1:0]     o_total_weight,
    output logic                           o_all_reached
);

    localparam int NB    = $clog2(MAX_NODES);
    localparam int NCW   = NB + 1;
    localparam int WB    = (WEIGHT_BITS < WEIGHT_IN_BITS) ? WEIGHT_BITS : WEIGHT_IN_BITS;
    localparam int DEPTH = MAX_NODES * MAX_NODES;
    localparam int AW    = $clog2(DEPTH);
    localparam int SUMW  = ((WB > TOTAL_BITS) ? WB : TOTAL_BITS) + 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_INIT  = 6'b000100,
        S_PASS  = 6'b001000,
        S_NEXT  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    function automatic logic [AW-1:0] adj_addr(input logic [NB-1:0] x, input logic [NB-1:0] y);
        logic [NB-1:0] lo;
        logic [NB-1:0] hi;
        lo = (x < y) ? x : y;
        hi = (x < y) ? y : x;
        return AW'(32'(lo) * MAX_NODES + 32'(hi));
    endfunction

    t_state                r_state, n_state;
    logic [CFG_BITS-1:0]   r_node_count, n_node_count;
    logic [NCW-1:0]        r_n, n_n;
    logic [AW-1:0]         r_clr, n_clr;
    logic [NB-1:0]         r_u, n_u;
    logic [NCW-1:0]        r_step, n_step;
    logic [TOTAL_BITS-1:0] r_total, n_total;
    logic                  r_reached, n_reached;
    logic                  r_out_valid, n_out_valid;
    logic [TOTAL_BITS-1:0] r_out_total, n_out_total;
    logic                  r_out_reached, n_out_reached;

    logic                  accept;
    logic                  in_range;
    logic [NB-1:0]         a_n;
    logic [NB-1:0]         b_n;
    logic [NCW-1:0]        n_eff;
    logic                  adj_we;
    logic [AW-1:0]         adj_waddr;
    logic [WB:0]           adj_wdata;
    logic [WB:0]           adj_rdata;
    logic [NB-1:0]         rd_node;
    t_pass_ctl             pass_ctl;
    t_pass_sts             pass_sts;
    logic [NB-1:0]         pick;
    logic [WB-1:0]         pw;
    logic [SUMW-1:0]       sum;

    assign o_in_ready     = (r_state == S_IDLE);
    assign accept         = i_in_valid && o_in_ready;
    assign in_range       = (32'(i_node_a) < 32'(MAX_NODES)) && (32'(i_node_b) < 32'(MAX_NODES));
    assign a_n            = NB'(i_node_a);
    assign b_n            = NB'(i_node_b);
    assign o_out_valid    = r_out_valid;
    assign o_total_weight = r_out_total;
    assign o_all_reached  = r_out_reached;

    assign n_eff = (r_node_count == '0) ? NCW'(1) :
                   (32'(r_node_count) > 32'(MAX_NODES)) ? NCW'(MAX_NODES) :
                   NCW'(r_node_count);

    assign adj_we    = (r_state == S_CLEAR) || (accept && in_range);
    assign adj_waddr = (r_state == S_CLEAR) ? r_clr : adj_addr(a_n, b_n);
    assign adj_wdata = (r_state == S_CLEAR) ? '0 : {1'b1, i_edge_weight[WB-1:0]};

    assign sum = SUMW'(r_total) + SUMW'(pw);

    mstw_ram #(
        .WIDTH (WB + 1),
        .DEPTH (DEPTH)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_addr(r_u, rd_node)),
        .o_rdata (adj_rdata)
    );

    mstw_relax #(
        .MAX_NODES (MAX_NODES),
        .WEIGHT_W  (WB)
    ) u_relax (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (pass_ctl),
        .i_n         (r_n),
        .i_adj_rdata (adj_rdata),
        .o_rd_node   (rd_node),
        .o_sts       (pass_sts),
        .o_pick      (pick),
        .o_pw        (pw)
    );

    always_comb begin
        n_state       = r_state;
        n_node_count  = r_node_count;
        n_n           = r_n;
        n_clr         = r_clr;
        n_u           = r_u;
        n_step        = r_step;
        n_total       = r_total;
        n_reached     = r_reached;
        n_out_valid   = r_out_valid;
        n_out_total   = r_out_total;
        n_out_reached = r_out_reached;
        pass_ctl      = '0;

        if (i_cfg_we) begin
            n_node_count = i_cfg_wdata;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_clr   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && i_last_edge) begin
                    n_n     = n_eff;
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                pass_ctl.init = 1'b1;
                n_total       = '0;
                n_u           = '0;
                n_step        = '0;
                if (r_n == NCW'(1)) begin
                    n_reached = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    pass_ctl.start = 1'b1;
                    n_state        = S_PASS;
                end
            end
            S_PASS: begin
                if (pass_sts.done) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (!pass_sts.found) begin
                    n_reached = 1'b0;
                    n_state   = S_DONE;
                end else begin
                    pass_ctl.commit = 1'b1;
                    n_total = (sum > SUMW'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
                    n_u     = pick;
                    n_step  = r_step + 1'b1;
                    if (NCW'(r_step + 1'b1) == NCW'(r_n - 1'b1)) begin
                        n_reached = 1'b1;
                        n_state   = S_DONE;
                    end else begin
                        pass_ctl.start = 1'b1;
                        n_state        = S_PASS;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_total   = r_total;
                    n_out_reached = r_reached;
                    n_clr         = '0;
                    n_state       = S_CLEAR;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_node_count <= CFG_RESET;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_node_count <= n_node_count;
            r_clr        <= n_clr;
            r_out_valid  <= n_out_valid;
        end
        r_n           <= n_n;
        r_u           <= n_u;
        r_step        <= n_step;
        r_total       <= n_total;
        r_reached     <= n_reached;
        r_out_total   <= n_out_total;
        r_out_reached <= n_out_reached;
    end

endmodule

`default_nettype wire

@@ bench/tb_min_spanning_tree_weight_top.sv @@
// Testbench for min_spanning_tree_weight_top: edge beats in, tree weight beats out.
// Self-checking against a behavioral Prim model; directed table, then random graphs.
// Depends on mstw_pkg and the RTL of the block.
`default_nettype none

module tb_min_spanning_tree_weight_top
    import mstw_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD = 4;
    localparam int NODES       = 32;
    localparam int SETTLE      = NODES * NODES + 64;
    localparam int ITEM_GOAL   = 1400;
    localparam int LIMIT_NS    = 200_000_000;
    localparam int PLAN_ROWS   = 18;

    typedef struct packed {
        logic [NODE_BITS-1:0]      a;
        logic [NODE_BITS-1:0]      b;
        logic [WEIGHT_IN_BITS-1:0] w;
        logic                      last;
    } t_edge_beat;

    typedef struct packed {
        logic [TOTAL_BITS-1:0] total;
        logic                  reached;
    } t_mst_result;

    typedef struct packed {
        bit                  set_cfg;
        logic [CFG_BITS-1:0] cfg;
        t_edge_beat          beat;
        bit                  typed;
        t_mst_result         want;
    } t_step;

    // typed rows carry their tree result; the rest go through the model
    localparam t_step PLAN [PLAN_ROWS] = '{
        '{1'b0, 6'd0,  '{5'd0,  5'd1,  16'd5,     1'b1}, 1'b1, '{21'd5,      1'b0}},
        '{1'b1, 6'd1,  '{5'd0,  5'd0,  16'd7,     1'b1}, 1'b1, '{21'd0,      1'b1}},
        '{1'b1, 6'd0,  '{5'd31, 5'd31, 16'hFFFF,  1'b1}, 1'b1, '{21'd0,      1'b1}},
        '{1'b1, 6'd2,  '{5'd0,  5'd1,  16'hFFFF,  1'b0}, 1'b0, '{21'd0,      1'b0}},
        '{1'b0, 6'd0,  '{5'd0,  5'd1,  16'd3,     1'b1}, 1'b1, '{21'd3,      1'b1}},
        '{1'b0, 6'd0,  '{5'd1,  5'd0,  16'd0,     1'b1}, 1'b1, '{21'd0,      1'b1}},
        '{1'b1, 6'd63, '{5'd31, 5'd0,  16'hFFFF,  1'b1}, 1'b1, '{21'd65535,  1'b0}},
        '{1'b1, 6'd3,  '{5'd0,  5'd1,  16'd10,    1'b0}, 1'b0, '{21'd0,      1'b0}},
        '{1'b0, 6'd0,  '{5'd1,  5'd2,  16'd20,    1'b0}, 1'b0, '{21'd0,      1'b0}},
        '{1'b0, 6'd0,  '{5'd0,  5'd2,  16'd15,    1'b0}, 1'b0, '{21'd0,      1'b0}},
        '{1'b0, 6'd0,  '{5'd2,  5'd2,  16'd1,     1'b0}, 1'b0, '{21'd0,      1'b0}},
        '{1'b0, 6'd0,  '{5'd0,  5'd5,  16'd1,     1'b0}, 1'b0, '{21'd0,      1'b0}},
        '{1'b0, 6'd0,  '{5'd2,  5'd1,  16'd30,    1'b1}, 1'b0, '{21'd0,      1'b0}},
        '{1'b1, 6'd4,  '{5'd0,  5'd1,  16'hFFFF,  1'b0}, 1'b0, '{21'd0,      1'b0}},
        '{1'b0, 6'd0,  '{5'd2,  5'd1,  16'hFFFF,  1'b0}, 1'b0, '{21'd0,      1'b0}},
        '{1'b0, 6'd0,  '{5'd3,  5'd2,  16'hFFFF,  1'b1}, 1'b1, '{21'd196605, 1'b1}},
        '{1'b0, 6'd0,  '{5'd0,  5'd1,  16'd4,     1'b0}, 1'b0, '{21'd0,      1'b0}},
        '{1'b0, 6'd0,  '{5'd2,  5'd3,  16'd5,     1'b1}, 1'b1, '{21'd4,      1'b0}}
    };

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_BITS-1:0]       i_cfg_wdata = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [NODE_BITS-1:0]      i_node_a = '0;
    logic [NODE_BITS-1:0]      i_node_b = '0;
    logic [WEIGHT_IN_BITS-1:0] i_edge_weight = '0;
    logic                      i_last_edge = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [TOTAL_BITS-1:0]     o_total_weight;
    logic                      o_all_reached;

    // model state
    logic [WEIGHT_IN_BITS-1:0] weight_mem [NODES][NODES];
    bit                        link_mark  [NODES][NODES];
    logic [CFG_BITS-1:0]       node_count_model;

    t_mst_result tree_expect [$];
    t_edge_beat  graph_beats [$];

    bit steady_flow = 1'b0;
    int mismatch_count = 0;
    int results_seen = 0;
    int beats_sent = 0;
    int graphs_sent = 0;
    int open_graphs = 0;
    int cfg_writes = 0;
    int top_total = 0;

    min_spanning_tree_weight_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_node_a       (i_node_a),
        .i_node_b       (i_node_b),
        .i_edge_weight  (i_edge_weight),
        .i_last_edge    (i_last_edge),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_total_weight (o_total_weight),
        .o_all_reached  (o_all_reached)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    initial begin
        #LIMIT_NS;
        $display("Mismatches found");
        $finish;
    end

    function automatic int active_nodes(input logic [CFG_BITS-1:0] cfg);
        if (cfg == 0) return 1;
        if (cfg > NODES) return NODES;
        return int'(cfg);
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [WEIGHT_IN_BITS-1:0] rand_weight();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 5) return WEIGHT_IN_BITS'($urandom_range(0, 15));
        return WEIGHT_IN_BITS'($urandom_range(0, 65535));
    endfunction

    // Prim from node 0 over the active nodes, saturating sum
    function automatic t_mst_result solve_mst();
        t_mst_result               r;
        bit                        joined [NODES];
        bit                        known  [NODES];
        logic [WEIGHT_IN_BITS-1:0] best   [NODES];
        logic [WEIGHT_IN_BITS-1:0] pw;
        int                        n, u, pick, sum, round;
        bit                        found, ok;
        n = active_nodes(node_count_model);
        foreach (joined[v]) begin
            joined[v] = 1'b0;
            known[v]  = 1'b0;
            best[v]   = '0;
        end
        sum = 0;
        ok = 1'b1;
        u = 0;
        joined[0] = 1'b1;
        for (round = 0; round < n; round++) begin
            for (int v = 0; v < n; v++) begin
                if (link_mark[u][v] && !joined[v] &&
                    (!known[v] || weight_mem[u][v] < best[v])) begin
                    known[v] = 1'b1;
                    best[v]  = weight_mem[u][v];
                end
            end
            if (round == n - 1) break;
            found = 1'b0;
            pick = 0;
            pw = '0;
            for (int v = 0; v < n; v++) begin
                if (!joined[v] && known[v] && (!found || best[v] < pw)) begin
                    found = 1'b1;
                    pick  = v;
                    pw    = best[v];
                end
            end
            if (!found) begin
                ok = 1'b0;
                break;
            end
            joined[pick] = 1'b1;
            if (sum + int'(pw) > int'(TOTAL_MAX)) sum = int'(TOTAL_MAX);
            else sum += int'(pw);
            u = pick;
        end
        r.total   = sum[TOTAL_BITS-1:0];
        r.reached = ok;
        return r;
    endfunction

    task automatic absorb_beat(input t_edge_beat b, input bit typed, input t_mst_result want);
        t_mst_result r;
        weight_mem[b.a][b.b] = b.w;
        weight_mem[b.b][b.a] = b.w;
        link_mark[b.a][b.b]  = 1'b1;
        link_mark[b.b][b.a]  = 1'b1;
        beats_sent++;
        if (b.last) begin
            r = solve_mst();
            if (!r.reached) open_graphs++;
            if (int'(r.total) > top_total) top_total = int'(r.total);
            tree_expect.insert(tree_expect.size(), typed ? want : r);
            foreach (link_mark[i, j]) link_mark[i][j] = 1'b0;
            graphs_sent++;
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endtask

    task automatic check_result(input t_mst_result got);
        t_mst_result want;
        results_seen++;
        if (tree_expect.size() == 0) begin
            report_mismatch($sformatf("result %0d with nothing pending: total %0d reached %0b",
                                      results_seen, got.total, got.reached));
            return;
        end
        want = tree_expect.pop_front();
        if (got.total !== want.total || got.reached !== want.reached)
            report_mismatch($sformatf(
                "result %0d: total exp %0d got %0d, all_reached exp %0b got %0b",
                results_seen, want.total, got.total, want.reached, got.reached));
    endtask

    // called at a rising edge; returns at the edge where the beat is taken
    task automatic send_beat(input t_edge_beat b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_node_a      <= b.a;
        i_node_b      <= b.b;
        i_edge_weight <= b.w;
        i_last_edge   <= b.last;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic hold_until_idle();
        i_in_valid <= 1'b0;
        while (tree_expect.size() != 0) @(posedge i_clk);
        // the adjacency clear pass follows each result
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_node_count(input logic [CFG_BITS-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        node_count_model = value;
        cfg_writes++;
    endtask

    task automatic build_graph(input int n);
        int         order [NODES];
        int         kind, extra, i, j, tmp, skip;
        bit         all_max;
        t_edge_beat e;
        graph_beats.delete();
        kind = $urandom_range(0, 9);
        all_max = (kind == 9);
        for (i = 0; i < n; i++) order[i] = i;
        for (i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        // kind 7 drops one tree link to split the graph, kind 8 is noise only
        skip = (kind == 7 && n > 1) ? $urandom_range(1, n - 1) : 0;
        if (kind != 8) begin
            for (i = 1; i < n; i++) begin
                if (i == skip) continue;
                e.a = NODE_BITS'(order[i]);
                e.b = NODE_BITS'(order[$urandom_range(0, i - 1)]);
                if ($urandom_range(0, 1) == 1) {e.a, e.b} = {e.b, e.a};
                e.w = all_max ? '1 : rand_weight();
                e.last = 1'b0;
                graph_beats.insert(graph_beats.size(), e);
            end
        end
        extra = (kind == 7 || kind == 9) ? 0 : $urandom_range(0, (n <= 2) ? 6 : n);
        for (i = 0; i < extra; i++) begin
            if (graph_beats.size() != 0 && $urandom_range(0, 3) == 0) begin
                e = graph_beats[$urandom_range(0, graph_beats.size() - 1)];
                {e.a, e.b} = {e.b, e.a};
            end else begin
                e.a = NODE_BITS'($urandom_range(0, n - 1));
                e.b = NODE_BITS'($urandom_range(0, n - 1));
            end
            e.w = rand_weight();
            e.last = 1'b0;
            graph_beats.insert(graph_beats.size(), e);
        end
        if (kind == 8) begin
            extra = $urandom_range(1, 12);
            for (i = 0; i < extra; i++) begin
                e.a = NODE_BITS'($urandom_range(0, NODES - 1));
                e.b = NODE_BITS'($urandom_range(0, NODES - 1));
                e.w = rand_weight();
                e.last = 1'b0;
                graph_beats.insert(graph_beats.size(), e);
            end
        end else if (!all_max && n < NODES) begin
            // links reaching past the active nodes
            extra = $urandom_range(0, 2);
            for (i = 0; i < extra; i++) begin
                e.a = NODE_BITS'($urandom_range(n, NODES - 1));
                e.b = NODE_BITS'($urandom_range(0, NODES - 1));
                e.w = rand_weight();
                e.last = 1'b0;
                graph_beats.insert(graph_beats.size(), e);
            end
        end
        for (i = graph_beats.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            e = graph_beats[i];
            graph_beats[i] = graph_beats[j];
            graph_beats[j] = e;
        end
        if (graph_beats.size() == 0) begin
            e.a = NODE_BITS'($urandom_range(0, NODES - 1));
            e.b = NODE_BITS'($urandom_range(0, NODES - 1));
            e.w = rand_weight();
            e.last = 1'b0;
            graph_beats.insert(graph_beats.size(), e);
        end
        graph_beats[graph_beats.size() - 1].last = 1'b1;
    endtask

    // result side: random stalls, check on every accepted beat
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                check_result(t_mst_result'{o_total_weight, o_all_reached});
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (!steady_flow && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    initial begin
        int          phase, graphs, r;
        logic [5:0]  cfg;
        t_mst_result none;
        none = '0;
        node_count_model = CFG_RESET;
        foreach (link_mark[i, j]) link_mark[i][j] = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < PLAN_ROWS; k++) begin
            if (PLAN[k].set_cfg) begin
                hold_until_idle();
                write_node_count(PLAN[k].cfg);
            end
            send_beat(PLAN[k].beat);
            absorb_beat(PLAN[k].beat, PLAN[k].typed, PLAN[k].want);
        end

        phase = 0;
        while (beats_sent < ITEM_GOAL + PLAN_ROWS) begin
            case (phase)
                0: cfg = 6'd32;
                1: cfg = 6'd0;
                2: cfg = 6'd63;
                3: cfg = 6'd1;
                4: cfg = 6'd2;
                default: begin
                    r = $urandom_range(0, 99);
                    if (r < 55) cfg = 6'($urandom_range(1, 8));
                    else if (r < 80) cfg = 6'($urandom_range(9, 20));
                    else if (r < 95) cfg = 6'($urandom_range(21, 32));
                    else cfg = (r < 97) ? 6'd0 : 6'($urandom_range(33, 63));
                end
            endcase
            hold_until_idle();
            steady_flow = (phase % 4 == 3);
            write_node_count(cfg);
            graphs = $urandom_range(3, 8);
            repeat (graphs) begin
                build_graph(active_nodes(node_count_model));
                foreach (graph_beats[i]) begin
                    send_beat(graph_beats[i]);
                    absorb_beat(graph_beats[i], 1'b0, none);
                end
            end
            phase++;
        end

        hold_until_idle();
        $display("Sent %0d edge beats in %0d graphs over %0d node-count settings.",
                 beats_sent, graphs_sent, cfg_writes);
        $display("Checked %0d tree results, %0d with unreached nodes, largest total %0d.",
                 results_seen, open_graphs, top_total);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/mstw_pkg.sv
rtl/mstw_ram.sv
rtl/mstw_relax.sv
rtl/min_spanning_tree_weight_top.sv
bench/tb_min_spanning_tree_weight_top.sv
